@@ rtl/stgrq_pkg.sv @@
package stgrq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TRACK_WIDTH = 16;
    localparam int TAG_WIDTH   = 16;
    localparam int FIELD_W     = 16;
    localparam int CNT_W       = 7;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] track_number;
        logic [FIELD_W-1:0] request_tag;
    } t_in_item;

    typedef struct packed {
        logic               head_valid;
        logic [FIELD_W-1:0] head_track;
        logic [FIELD_W-1:0] head_tag;
        logic [CNT_W-1:0]   queue_count;
        logic               dropped;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

@@ rtl/stgrq_ctrl.sv @@
module stgrq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output stgrq_pkg::t_dp_cmd o_cmd
);
    import stgrq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_WRITE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit  = (r_state == S_WRITE) && slot_free;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/stgrq_dp.sv @@
module stgrq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stgrq_pkg::t_dp_cmd   i_cmd,
    input  stgrq_pkg::t_in_item  i_in_data,
    output stgrq_pkg::t_out_item o_out_data
);
    import stgrq_pkg::*;

    logic [TRACK_WIDTH-1:0] r_track [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   r_tag   [QUEUE_DEPTH];
    logic [TRACK_WIDTH-1:0] n_track [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   n_tag   [QUEUE_DEPTH];
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_kind;
    logic [TRACK_WIDTH-1:0] r_trk;
    logic [TAG_WIDTH-1:0]   r_tg;
    logic [QUEUE_DEPTH-1:0] r_match, n_match;
    logic [QUEUE_DEPTH-1:0] seen, cand, shift_sel;
    logic                   add_ok, rem_ok, full;
    t_out_item              r_out, n_out;

    assign full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign add_ok = (r_kind == KIND_ADD) && !full;
    assign rem_ok = (r_kind == KIND_REMOVE) && (r_count != '0);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_match[i] = (CNT_W'(i) < r_count)
                && (r_track[i] == i_in_data.track_number[TRACK_WIDTH-1:0]);
        end
    end

    always_comb begin
        logic [QUEUE_DEPTH-1:0] low_mask;
        low_mask = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            low_mask = (QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1);
            seen[i]  = |(r_match & low_mask);
            cand[i]  = (seen[i] && !r_match[i]) || !(CNT_W'(i) < r_count);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            low_mask     = (QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1);
            shift_sel[i] = |(cand & low_mask);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_track[i] = r_track[i];
            n_tag[i]   = r_tag[i];
        end
        n_count = r_count;
        if (add_ok) begin
            if (cand[0]) begin
                n_track[0] = r_trk;
                n_tag[0]   = r_tg;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (shift_sel[i]) begin
                    n_track[i] = r_track[i-1];
                    n_tag[i]   = r_tag[i-1];
                end else if (cand[i]) begin
                    n_track[i] = r_trk;
                    n_tag[i]   = r_tg;
                end
            end
            n_count = r_count + CNT_W'(1);
        end else if (rem_ok) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_track[i] = r_track[i+1];
                n_tag[i]   = r_tag[i+1];
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_out.head_valid  = (n_count != '0);
        n_out.head_track  = n_out.head_valid ? FIELD_W'(n_track[0]) : '0;
        n_out.head_tag    = n_out.head_valid ? FIELD_W'(n_tag[0]) : '0;
        n_out.queue_count = n_count;
        n_out.dropped     = (r_kind == KIND_ADD) && full;
    end

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_in_data.kind;
            r_trk   <= i_in_data.track_number[TRACK_WIDTH-1:0];
            r_tg    <= i_in_data.request_tag[TAG_WIDTH-1:0];
            r_match <= n_match;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_track[i] <= n_track[i];
                r_tag[i]   <= n_tag[i];
            end
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/same_track_grouping_request_queue_top.sv @@
// Channel  Direction  Handshake                  Payload
// input    in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
// output   out        o_out_valid / i_out_stall  o_out_data (t_out_item)
//
// Each item is taken in S_IDLE, where the transfer cycle compares the new track
// against every queued cell; S_WRITE then shifts the cell row and loads the result.
// S_WRITE waits while a previous result is still held on a stall.
// Reset is synchronous and empties the queue; no clearing pass is needed.
module same_track_grouping_request_queue_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  stgrq_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stgrq_pkg::t_out_item o_out_data
);
    import stgrq_pkg::*;

    t_dp_cmd cmd;

    stgrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    stgrq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

@@ rtl/stgrq_checker.sv @@
module stgrq_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input stgrq_pkg::t_out_item o_out_data
);
    import stgrq_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output changed");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.head_valid == (o_out_data.queue_count != '0)))
        else $error("head valid disagrees with count");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dropped
            |-> o_out_data.queue_count == CNT_W'(QUEUE_DEPTH))
        else $error("dropped while not full");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on consecutive cycles");

endmodule

bind same_track_grouping_request_queue_top stgrq_checker u_checker (.*);

@@ sim/tb_same_track_grouping_request_queue_top.sv @@
module tb_same_track_grouping_request_queue_top;
    import stgrq_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    bit [TRACK_WIDTH-1:0] shadow_tracks[$];
    bit [TAG_WIDTH-1:0]   shadow_tags[$];
    t_out_item            awaited_status[$];
    logic [FIELD_W-1:0]   track_pool[6];

    bit idle_enable    = 1'b1;
    int out_hold_left  = 0;
    int mismatch_count = 0;
    int n_requests     = 0;
    int n_adds         = 0;
    int n_removes      = 0;
    int n_refused      = 0;
    int n_grouped      = 0;
    int n_empty_remove = 0;
    int peak_depth     = 0;
    int n_checked      = 0;

    same_track_grouping_request_queue_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_out_item predict_queue_status(t_in_item item);
        t_out_item status;
        int        slot;
        int        idx;
        bit        found;
        status = '0;
        found  = 1'b0;
        n_requests++;
        if (item.kind == KIND_ADD) begin
            n_adds++;
            if (shadow_tracks.size() >= QUEUE_DEPTH) begin
                status.dropped = 1'b1;
                n_refused++;
            end else begin
                slot = shadow_tracks.size();
                for (idx = 0; idx < shadow_tracks.size() && !found; idx++) begin
                    if (shadow_tracks[idx] == item.track_number[TRACK_WIDTH-1:0]) begin
                        found = 1'b1;
                        slot  = idx + 1;
                        while (slot < shadow_tracks.size() &&
                               shadow_tracks[slot] == item.track_number[TRACK_WIDTH-1:0])
                            slot++;
                    end
                end
                if (found)
                    n_grouped++;
                shadow_tracks.insert(slot, item.track_number[TRACK_WIDTH-1:0]);
                shadow_tags.insert(slot, item.request_tag[TAG_WIDTH-1:0]);
            end
        end else begin
            n_removes++;
            if (shadow_tracks.size() > 0) begin
                void'(shadow_tracks.pop_front());
                void'(shadow_tags.pop_front());
            end else begin
                n_empty_remove++;
            end
        end
        if (shadow_tracks.size() > peak_depth)
            peak_depth = shadow_tracks.size();
        if (shadow_tracks.size() > 0) begin
            status.head_valid = 1'b1;
            status.head_track = FIELD_W'(shadow_tracks[0]);
            status.head_tag   = FIELD_W'(shadow_tags[0]);
        end
        status.queue_count = CNT_W'(shadow_tracks.size());
        return status;
    endfunction

    task automatic issue_request(input logic kind, input logic [FIELD_W-1:0] trk,
                                 input logic [FIELD_W-1:0] tag);
        t_in_item item;
        item.kind         = kind;
        item.track_number = trk;
        item.request_tag  = tag;
        if (idle_enable && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 21);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        awaited_status.push_back(predict_queue_status(item));
    endtask

    task automatic hold_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (awaited_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] expv,
                                input logic [31:0] actv);
        if (actv !== expv) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin : status_monitor
        t_out_item want;
        if (out_hold_left > 0) begin
            i_out_stall <= 1'b1;
            out_hold_left <= out_hold_left - 1;
        end else begin
            i_out_stall <= idle_enable && ($urandom_range(99) < 21);
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_status.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none, actual %0h",
                         $time, o_out_data);
            end else begin
                want = awaited_status.pop_front();
                n_checked++;
                report_field("head_valid",  32'(want.head_valid),  32'(o_out_data.head_valid));
                report_field("head_track",  32'(want.head_track),  32'(o_out_data.head_track));
                report_field("head_tag",    32'(want.head_tag),    32'(o_out_data.head_tag));
                report_field("queue_count", 32'(want.queue_count), 32'(o_out_data.queue_count));
                report_field("dropped",     32'(want.dropped),     32'(o_out_data.dropped));
            end
        end
    end

    task automatic refresh_track_pool();
        int idx;
        for (idx = 0; idx < 6; idx++)
            track_pool[3'(idx)] = FIELD_W'($urandom);
        if ($urandom_range(1))
            track_pool[0] = '0;
        if ($urandom_range(1))
            track_pool[5] = '1;
    endtask

    function automatic logic [FIELD_W-1:0] pick_track();
        if ($urandom_range(99) < 75)
            return track_pool[3'($urandom_range(5))];
        return FIELD_W'($urandom);
    endfunction

    task automatic test_directed_cases();
        issue_request(KIND_REMOVE, 16'h0000, 16'h0000);
        issue_request(KIND_ADD,    16'h0000, 16'h0000);
        issue_request(KIND_ADD,    16'hFFFF, 16'hFFFF);
        issue_request(KIND_ADD,    16'h0000, 16'h0001);
        issue_request(KIND_ADD,    16'h1234, 16'hA5A5);
        issue_request(KIND_ADD,    16'hFFFF, 16'h0002);
        issue_request(KIND_ADD,    16'h0000, 16'h0003);
        issue_request(KIND_REMOVE, 16'hFFFF, 16'hFFFF);
        issue_request(KIND_ADD,    16'h0000, 16'h0004);
        issue_request(KIND_ADD,    16'h5A5A, 16'h8000);
        repeat (9)
            issue_request(KIND_REMOVE, 16'hAAAA, 16'h5555);
        issue_request(KIND_ADD,    16'h8001, 16'h7FFE);
        issue_request(KIND_ADD,    16'h8001, 16'h0001);
        issue_request(KIND_REMOVE, 16'h0000, 16'h0000);
        issue_request(KIND_REMOVE, 16'h0000, 16'h0000);
    endtask

    task automatic test_fill_and_overflow();
        refresh_track_pool();
        while (shadow_tracks.size() < QUEUE_DEPTH)
            issue_request(KIND_ADD, pick_track(), FIELD_W'($urandom));
        issue_request(KIND_ADD, track_pool[0], 16'hFFFF);
        issue_request(KIND_ADD, 16'hFFFF, 16'h0000);
        issue_request(KIND_ADD, FIELD_W'($urandom), FIELD_W'($urandom));
        issue_request(KIND_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom));
        issue_request(KIND_ADD, pick_track(), FIELD_W'($urandom));
        issue_request(KIND_ADD, pick_track(), FIELD_W'($urandom));
        while (shadow_tracks.size() > 0)
            issue_request(KIND_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom));
        issue_request(KIND_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic run_random_stretch(input int count, input int add_pct);
        int                 sent;
        int                 burst;
        logic [FIELD_W-1:0] trk;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < add_pct) begin
                trk   = pick_track();
                burst = ($urandom_range(99) < 30) ? $urandom_range(4, 2) : 1;
                repeat (burst) begin
                    issue_request(KIND_ADD, trk, FIELD_W'($urandom));
                    sent++;
                end
            end else begin
                issue_request(KIND_REMOVE, FIELD_W'($urandom), FIELD_W'($urandom));
                sent++;
            end
            if ($urandom_range(99) < 3)
                refresh_track_pool();
        end
    endtask

    task automatic test_random_mix();
        int bias[7] = '{75, 50, 30, 85, 45, 20, 60};
        int phase;
        for (phase = 0; phase < 7; phase++) begin
            refresh_track_pool();
            run_random_stretch(100, bias[3'(phase)]);
        end
    endtask

    task automatic test_output_backpressure();
        refresh_track_pool();
        out_hold_left = 300;
        run_random_stretch(40, 65);
    endtask

    task automatic test_steady_stream();
        idle_enable = 1'b0;
        refresh_track_pool();
        run_random_stretch(60, 70);
        run_random_stretch(60, 35);
        idle_enable = 1'b1;
    endtask

    task automatic test_drain_pause();
        hold_input();
        wait_drained();
        refresh_track_pool();
        run_random_stretch(15, 80);
        hold_input();
        wait_drained();
        run_random_stretch(15, 20);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_fill_and_overflow();
        test_random_mix();
        test_output_backpressure();
        test_steady_stream();
        test_drain_pause();
        hold_input();
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests: %0d adds (%0d joined a track group, %0d refused when full),",
                 n_requests, n_adds, n_grouped, n_refused);
        $display("%0d removes (%0d on an empty queue), peak depth %0d, %0d results checked.",
                 n_removes, n_empty_remove, peak_depth, n_checked);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", awaited_status.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
